### design/tsnb_pkg.sv
package tsnb_pkg;

    localparam int COORD_WIDTH = 32;
    // Vertex differences, cross products and their magnitudes.
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int LW = $clog2(XW + 1);
    // The largest scaled magnitude lies in [2^30, 2^31).
    localparam int MW = 31;
    localparam int SW = 2 * MW + 2;
    localparam int SQ_STEPS = SW / 2;
    localparam int RW = SQ_STEPS;
    localparam int NW = MW + 30 + 1;
    localparam int QW = MW;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
    } t_out_req;

    // Everything that travels with a triangle down the pipeline.
    typedef struct packed {
        logic [2:0][31:0]   lo;
        logic [2:0][31:0]   hi;
        logic [2:0][31:0]   ctr;
        logic [2:0]         neg;
        logic               zero;
        logic [2:0][MW-1:0] m;
    } t_tri;

    function automatic logic signed [31:0] sext(input logic [31:0] x);
        return 32'(signed'(x[COORD_WIDTH-1:0]));
    endfunction

    function automatic logic [LW-1:0] bitlen(input logic [XW-1:0] x);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < XW; i++) begin
            if (x[i]) n = LW'(i + 1);
        end
        return n;
    endfunction

endpackage

### design/tsnb_front.sv
module tsnb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  tsnb_pkg::t_in_req i_req,
    output logic             o_valid,
    output tsnb_pkg::t_tri   o_tri,
    output logic [63:0]      o_sum
);
    import tsnb_pkg::*;

    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] vc [3];
    logic signed [31:0] n_lo [3];
    logic signed [31:0] n_hi [3];

    logic [8:1] r_v;
    logic signed [DW-1:0] r1_d1 [3];
    logic signed [DW-1:0] r1_d2 [3];
    logic [2:0][31:0]     r1_lo, r1_hi;
    logic signed [PW-1:0] r2_p [6];
    t_tri                 r2_t, r3_t, r4_t, r5_t, r6_t, r7_t, r8_t;
    t_tri                 n_t2, n_t4, n_t6;
    logic signed [XW-1:0] r3_c [3];
    logic [XW-1:0]        r4_mag [3];
    logic [XW-1:0]        r4_or;
    logic [XW-1:0]        r5_mag [3];
    logic [LW-1:0]        r5_len;
    logic [2*MW-1:0]      r7_sq [3];
    logic [63:0]          r8_sum;
    logic [XW+MW-1:0]     sh [3];
    logic signed [32:0]   csum [3];

    always_comb begin
        va[0] = sext(i_req.a_x); va[1] = sext(i_req.a_y); va[2] = sext(i_req.a_z);
        vb[0] = sext(i_req.b_x); vb[1] = sext(i_req.b_y); vb[2] = sext(i_req.b_z);
        vc[0] = sext(i_req.c_x); vc[1] = sext(i_req.c_y); vc[2] = sext(i_req.c_z);
        n_t2      = '0;
        n_t2.lo   = r1_lo;
        n_t2.hi   = r1_hi;
        n_t4      = r3_t;
        n_t6      = r5_t;
        n_t6.zero = (r5_len == '0);
        for (int i = 0; i < 3; i++) begin
            n_lo[i] = va[i];
            n_hi[i] = va[i];
            if (vb[i] < n_lo[i]) n_lo[i] = vb[i];
            if (vc[i] < n_lo[i]) n_lo[i] = vc[i];
            if (vb[i] > n_hi[i]) n_hi[i] = vb[i];
            if (vc[i] > n_hi[i]) n_hi[i] = vc[i];
            csum[i] = 33'(signed'(r1_lo[i])) + 33'(signed'(r1_hi[i]));
            n_t2.ctr[i] = csum[i][32:1];
            n_t4.neg[i] = r3_c[i][XW-1];
            // Block normalization: shift so the largest magnitude fills 31 bits.
            sh[i] = {r5_mag[i], MW'(0)} >> r5_len;
            n_t6.m[i] = sh[i][MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d1[i] <= DW'(vb[i]) - DW'(va[i]);
                r1_d2[i] <= DW'(vc[i]) - DW'(va[i]);
                r1_lo[i] <= n_lo[i];
                r1_hi[i] <= n_hi[i];
            end

            r2_p[0] <= r1_d1[1] * r1_d2[2];
            r2_p[1] <= r1_d1[2] * r1_d2[1];
            r2_p[2] <= r1_d1[2] * r1_d2[0];
            r2_p[3] <= r1_d1[0] * r1_d2[2];
            r2_p[4] <= r1_d1[0] * r1_d2[1];
            r2_p[5] <= r1_d1[1] * r1_d2[0];
            r2_t    <= n_t2;

            for (int i = 0; i < 3; i++) r3_c[i] <= XW'(r2_p[2*i]) - XW'(r2_p[2*i+1]);
            r3_t <= r2_t;

            r4_t <= n_t4;
            for (int i = 0; i < 3; i++) begin
                r4_mag[i]   <= r3_c[i][XW-1] ? XW'(-r3_c[i]) : XW'(r3_c[i]);
            end
            r4_or <= (r3_c[0][XW-1] ? XW'(-r3_c[0]) : XW'(r3_c[0]))
                   | (r3_c[1][XW-1] ? XW'(-r3_c[1]) : XW'(r3_c[1]))
                   | (r3_c[2][XW-1] ? XW'(-r3_c[2]) : XW'(r3_c[2]));

            r5_t   <= r4_t;
            r5_mag <= r4_mag;
            r5_len <= bitlen(r4_or);

            r6_t <= n_t6;

            r7_t <= r6_t;
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= {MW'(0), r6_t.m[i]} * {MW'(0), r6_t.m[i]};
            end

            r8_t   <= r7_t;
            r8_sum <= 64'(r7_sq[0]) + 64'(r7_sq[1]) + 64'(r7_sq[2]);
        end
    end

    assign o_valid = r_v[8];
    assign o_tri   = r8_t;
    assign o_sum   = r8_sum;

endmodule

### design/tsnb_sqrt.sv
module tsnb_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  tsnb_pkg::t_tri          i_tri,
    input  logic [63:0]             i_sum,
    output logic                    o_valid,
    output tsnb_pkg::t_tri          o_tri,
    output logic [tsnb_pkg::RW-1:0] o_root
);
    import tsnb_pkg::*;

    logic        r_v [SQ_STEPS];
    logic [63:0] r_x [SQ_STEPS];
    logic [63:0] r_r [SQ_STEPS];
    t_tri        r_t [SQ_STEPS];

    // One result bit per stage, restoring digit-by-digit square root.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
        logic        v_in;
        logic [63:0] x_in, r_in, t;
        t_tri        t_in;
        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign x_in = i_sum;
            assign r_in = '0;
            assign t_in = i_tri;
        end else begin : g_rest
            assign v_in = r_v[k-1];
            assign x_in = r_x[k-1];
            assign r_in = r_r[k-1];
            assign t_in = r_t[k-1];
        end
        assign t = r_in + Bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k] <= t_in;
                if (x_in >= t) begin
                    r_x[k] <= x_in - t;
                    r_r[k] <= (r_in >> 1) + Bit;
                end else begin
                    r_x[k] <= x_in;
                    r_r[k] <= r_in >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[SQ_STEPS-1];
    assign o_tri   = r_t[SQ_STEPS-1];
    assign o_root  = r_r[SQ_STEPS-1][RW-1:0];

endmodule

### design/tsnb_div.sv
module tsnb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  tsnb_pkg::t_tri                i_tri,
    input  logic [tsnb_pkg::RW-1:0]       i_root,
    output logic                          o_valid,
    output tsnb_pkg::t_tri                o_tri,
    output logic [2:0][tsnb_pkg::QW-1:0]  o_q
);
    import tsnb_pkg::*;

    // Setup stage: rounded numerator m * 2^30 + root / 2 for each lane.
    logic                r0_v;
    t_tri                r0_t;
    logic [RW-1:0]       r0_d;
    logic [2:0][NW-1:0]  r0_n;

    logic                r_v [QW];
    t_tri                r_t [QW];
    logic [RW-1:0]       r_d [QW];
    logic [2:0][RW-1:0]  r_rem [QW];
    logic [2:0][QW-1:0]  r_low [QW];
    logic [2:0][QW-1:0]  r_q [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_t <= i_tri;
            r0_d <= i_root;
            for (int i = 0; i < 3; i++) begin
                r0_n[i] <= {1'b0, i_tri.m[i], 30'b0} + NW'(i_root >> 1);
            end
        end
    end

    // One quotient bit per stage in each of the three lanes.
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic               v_in;
        t_tri               t_in;
        logic [RW-1:0]      d_in;
        logic [2:0][RW-1:0] rem_in;
        logic [2:0][QW-1:0] low_in, q_in;
        logic [2:0][RW:0]   t;
        logic [2:0]         ge;

        if (k == 0) begin : g_first
            assign v_in = r0_v;
            assign t_in = r0_t;
            assign d_in = r0_d;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = RW'(r0_n[i] >> QW);
                assign low_in[i] = r0_n[i][QW-1:0];
            end
            assign q_in = '0;
        end else begin : g_rest
            assign v_in   = r_v[k-1];
            assign t_in   = r_t[k-1];
            assign d_in   = r_d[k-1];
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t[i]  = {rem_in[i], low_in[i][QW-1]};
                ge[i] = (t[i] >= {1'b0, d_in});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k] <= t_in;
                r_d[k] <= d_in;
                for (int i = 0; i < 3; i++) begin
                    r_rem[k][i] <= ge[i] ? RW'(t[i] - {1'b0, d_in}) : RW'(t[i]);
                    r_low[k][i] <= {low_in[i][QW-2:0], 1'b0};
                    r_q[k][i]   <= {q_in[i][QW-2:0], ge[i]};
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_tri   = r_t[QW-1];
    assign o_q     = r_q[QW-1];

endmodule

### design/triangle_setup_normal_bounds_top.sv
// Triangle setup unit: takes three Q16.16 vertices per triangle and returns its unit face
// normal in Q2.30, its axis-aligned bounding box and the box centroid. A new request is
// taken every cycle while the pipeline is not stalled. Each result goes through the
// differences, cross product, normalization and sum of squares, a one-bit-per-stage
// square root, a one-bit-per-stage divider and one output register. A stall from
// downstream holds the whole pipeline in place while an output is waiting. A triangle
// with a zero cross product yields an all-zero normal.
module triangle_setup_normal_bounds_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tsnb_pkg::t_in_req  i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output tsnb_pkg::t_out_req o_res
);
    import tsnb_pkg::*;

    logic               en;
    logic               f_valid, s_valid, d_valid;
    t_tri               f_tri, s_tri, d_tri;
    logic [63:0]        f_sum;
    logic [RW-1:0]      s_root;
    logic [2:0][QW-1:0] d_q;
    logic [2:0][31:0]   nrm;
    logic               r_valid;
    t_out_req           r_res;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;

    tsnb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (f_valid),
        .o_tri   (f_tri),
        .o_sum   (f_sum)
    );

    tsnb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_tri   (f_tri),
        .i_sum   (f_sum),
        .o_valid (s_valid),
        .o_tri   (s_tri),
        .o_root  (s_root)
    );

    tsnb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_tri   (s_tri),
        .i_root  (s_root),
        .o_valid (d_valid),
        .o_tri   (d_tri),
        .o_q     (d_q)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (d_tri.zero) begin
                nrm[i] = '0;
            end else if (d_tri.neg[i]) begin
                nrm[i] = 32'(-{1'b0, d_q[i]});
            end else begin
                nrm[i] = 32'({1'b0, d_q[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res.normal_x  <= nrm[0];
            r_res.normal_y  <= nrm[1];
            r_res.normal_z  <= nrm[2];
            r_res.box_min_x <= d_tri.lo[0];
            r_res.box_min_y <= d_tri.lo[1];
            r_res.box_min_z <= d_tri.lo[2];
            r_res.box_max_x <= d_tri.hi[0];
            r_res.box_max_y <= d_tri.hi[1];
            r_res.box_max_z <= d_tri.hi[2];
            r_res.center_x  <= d_tri.ctr[0];
            r_res.center_y  <= d_tri.ctr[1];
            r_res.center_z  <= d_tri.ctr[2];
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### dv/triangle_setup_normal_bounds_top_test.sv
`timescale 1ns / 1ps

module triangle_setup_normal_bounds_top_test;

    import tsnb_pkg::*;

    localparam int LATENCY = 73;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_in_req  i_req;
    logic     o_valid;
    logic     i_stall;
    t_out_req o_res;

    t_in_req  tri_pending[$];
    t_out_req setup_expected[$];
    int       mismatch_count;
    int       triangles_sent;
    int       results_seen;
    int       degenerate_count;
    int       send_idle_pct;
    int       recv_stall_pct;

    triangle_setup_normal_bounds_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Computes normal, box and centroid for one triangle.
    function automatic t_out_req setup_triangle(input t_in_req t);
        logic signed [63:0]  v[9];
        logic signed [63:0]  d1[3];
        logic signed [63:0]  d2[3];
        logic signed [127:0] cr[3];
        logic [127:0]        mag[3];
        logic [63:0]         m[3];
        logic [63:0]         sum;
        logic [63:0]         root;
        logic [63:0]         q;
        logic signed [63:0]  lo;
        logic signed [63:0]  hi;
        logic signed [63:0]  s;
        logic [31:0]         f[9];
        int                  blen;
        t_out_req            r;
        {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]} = t;
        for (int i = 0; i < 9; i++) v[i] = 64'(signed'(f[i]));
        for (int i = 0; i < 3; i++) begin
            d1[i] = v[3 + i] - v[i];
            d2[i] = v[6 + i] - v[i];
        end
        cr[0] = 128'(d1[1]) * 128'(d2[2]) - 128'(d1[2]) * 128'(d2[1]);
        cr[1] = 128'(d1[2]) * 128'(d2[0]) - 128'(d1[0]) * 128'(d2[2]);
        cr[2] = 128'(d1[0]) * 128'(d2[1]) - 128'(d1[1]) * 128'(d2[0]);
        blen = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
            for (int k = 0; k < 128; k++) if (mag[i][k] && k + 1 > blen) blen = k + 1;
        end
        r = '0;
        if (blen != 0) begin
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                if (blen > 31) m[i] = 64'(mag[i] >> (blen - 31));
                else m[i] = 64'(mag[i] << (31 - blen));
                sum = sum + m[i] * m[i];
            end
            root = isqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << 30) + (root >> 1)) / root;
                if (cr[i] < 0) q = -q;
                f[i] = q[31:0];
            end
            r.normal_x = f[0];
            r.normal_y = f[1];
            r.normal_z = f[2];
        end
        for (int i = 0; i < 3; i++) begin
            lo = v[i];
            hi = v[i];
            if (v[3 + i] < lo) lo = v[3 + i];
            if (v[6 + i] < lo) lo = v[6 + i];
            if (v[3 + i] > hi) hi = v[3 + i];
            if (v[6 + i] > hi) hi = v[6 + i];
            s = (lo + hi) >>> 1;
            f[i] = lo[31:0];
            f[3 + i] = hi[31:0];
            f[6 + i] = s[31:0];
        end
        r.box_min_x = f[0];
        r.box_min_y = f[1];
        r.box_min_z = f[2];
        r.box_max_x = f[3];
        r.box_max_y = f[4];
        r.box_max_z = f[5];
        r.center_x  = f[6];
        r.center_y  = f[7];
        r.center_z  = f[8];
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return 32'($signed($urandom_range(0, 8)) - 4);
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_tri(input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_pending.push_back({ax, ay, az, bx, by, bz, cx, cy, cz});
    endtask

    task automatic add_random_tri();
        logic [31:0] c[9];
        int          kind;
        for (int i = 0; i < 9; i++) c[i] = rand_coord();
        kind = $urandom_range(0, 9);
        // Some triangles collapse onto a point or a line to hit the zero normal.
        if (kind == 0) begin
            for (int i = 3; i < 9; i++) c[i] = c[i % 3];
        end else if (kind == 1) begin
            for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
        end
        add_tri(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (tri_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_req   <= tri_pending.pop_front();
                i_valid <= 1'b1;
                triangles_sent <= triangles_sent + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            setup_expected.push_back(setup_triangle(i_req));
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_out_req e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (setup_expected.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                e = setup_expected.pop_front();
                if (e.normal_x == 0 && e.normal_y == 0 && e.normal_z == 0)
                    degenerate_count++;
                if (o_res.normal_x !== e.normal_x) begin
                    $error("normal_x exp %0d got %0d", e.normal_x, o_res.normal_x);
                    mismatch_count++;
                end
                if (o_res.normal_y !== e.normal_y) begin
                    $error("normal_y exp %0d got %0d", e.normal_y, o_res.normal_y);
                    mismatch_count++;
                end
                if (o_res.normal_z !== e.normal_z) begin
                    $error("normal_z exp %0d got %0d", e.normal_z, o_res.normal_z);
                    mismatch_count++;
                end
                if (o_res.box_min_x !== e.box_min_x) begin
                    $error("box_min_x exp %0d got %0d", e.box_min_x, o_res.box_min_x);
                    mismatch_count++;
                end
                if (o_res.box_min_y !== e.box_min_y) begin
                    $error("box_min_y exp %0d got %0d", e.box_min_y, o_res.box_min_y);
                    mismatch_count++;
                end
                if (o_res.box_min_z !== e.box_min_z) begin
                    $error("box_min_z exp %0d got %0d", e.box_min_z, o_res.box_min_z);
                    mismatch_count++;
                end
                if (o_res.box_max_x !== e.box_max_x) begin
                    $error("box_max_x exp %0d got %0d", e.box_max_x, o_res.box_max_x);
                    mismatch_count++;
                end
                if (o_res.box_max_y !== e.box_max_y) begin
                    $error("box_max_y exp %0d got %0d", e.box_max_y, o_res.box_max_y);
                    mismatch_count++;
                end
                if (o_res.box_max_z !== e.box_max_z) begin
                    $error("box_max_z exp %0d got %0d", e.box_max_z, o_res.box_max_z);
                    mismatch_count++;
                end
                if (o_res.center_x !== e.center_x) begin
                    $error("center_x exp %0d got %0d", e.center_x, o_res.center_x);
                    mismatch_count++;
                end
                if (o_res.center_y !== e.center_y) begin
                    $error("center_y exp %0d got %0d", e.center_y, o_res.center_y);
                    mismatch_count++;
                end
                if (o_res.center_z !== e.center_z) begin
                    $error("center_z exp %0d got %0d", e.center_z, o_res.center_z);
                    mismatch_count++;
                end
            end
        end
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req = '0;
        mismatch_count = 0;
        triangles_sent = 0;
        results_seen = 0;
        degenerate_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed triangles: unit axes, extremes, degenerate shapes.
        add_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0);
        add_tri(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0);
        add_tri(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0);
        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(5, 6, 7, 5, 6, 7, 5, 6, 7);
        add_tri(0, 0, 0, 1, 1, 1, 2, 2, 2);
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        add_tri(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        add_tri(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        add_tri(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1, 0, 0);
        add_tri(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0);
        add_tri(32'hffff_fffd, 32'h0000_0003, 0, 32'hffff_fffe, 0, 1, 0, 32'h1, 32'h2);
        add_tri(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f);

        // Random triangles over the idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 71 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 71 : 0;
            if (ph == 3) begin
                send_idle_pct  = 7;
                recv_stall_pct = 7;
            end
            for (int n = 0; n < 500; n++) add_random_tri();
            while (tri_pending.size() != 0) @(posedge i_clk);
        end
        @(posedge i_clk);
        // Wait until the last request is taken and every result has come back.
        while (i_valid || setup_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d triangles, checked %0d results, %0d with a zero normal",
                 triangles_sent, results_seen, degenerate_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
